// File: sv/tscf_pkg.sv
// Shared types and constants for the text stream filter.
// Holds the configuration and job structs, register indexes and byte codes.
// No dependencies.
package tscf_pkg;

  localparam int LineDigitsDef = 6;
  localparam int QueueDepthDef = 4;
  localparam int CfgIdxW = 3;
  localparam int ExpMax = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NUMBER_ALL,
    CFG_NUMBER_NONBLANK,
    CFG_SQUEEZE_BLANK,
    CFG_SHOW_ENDS,
    CFG_SHOW_TABS,
    CFG_SHOW_NONPRINTING
  } cfg_idx_e;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  typedef struct packed {
    logic                   has_num;
    logic [2:0]             char_cnt;
    logic [ExpMax-1:0][7:0] chars;
  } job_t;

  localparam logic [7:0] ChTab      = 8'h09;
  localparam logic [7:0] ChNewline  = 8'h0A;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChDollar   = 8'h24;
  localparam logic [7:0] ChDash     = 8'h2D;
  localparam logic [7:0] ChZero     = 8'h30;
  localparam logic [7:0] ChQuestion = 8'h3F;
  localparam logic [7:0] ChUpperI   = 8'h49;
  localparam logic [7:0] ChUpperM   = 8'h4D;
  localparam logic [7:0] ChCaret    = 8'h5E;
  localparam logic [7:0] ChDel      = 8'h7F;
  localparam logic [7:0] CtrlLast   = 8'h1F;
  localparam logic [7:0] CaretOfs   = 8'h40;

endpackage

// File: sv/tscf_front.sv
// Front end of the text stream filter: accepts input beats and classifies them.
// Keeps line state and the BCD line number, and pushes one job per visible byte.
// Depends on tscf_pkg.
module tscf_front import tscf_pkg::*; #(
  parameter int LINE_DIGITS = LineDigitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               in_byte_i,
  input  logic                     q_full_i,
  output logic                     push_o,
  output job_t                     job_o,
  output logic [4*LINE_DIGITS-1:0] num_o
);

  localparam int NW = 4 * LINE_DIGITS;

  logic          line_start_q;
  logic [1:0]    blank_run_q, blank_run_d;
  logic [NW-1:0] bcd_q, bcd_d;
  logic          accept, is_nl, squeezed, want_num, carry;
  logic [3:0]    dig;
  logic [7:0]    c;
  logic [2:0]    n;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_nl      = (in_byte_i == ChNewline);
  assign num_o      = bcd_q;

  always_comb begin
    blank_run_d = blank_run_q;
    if (line_start_q) begin
      if (is_nl) begin
        blank_run_d = (blank_run_q == 2'd3) ? 2'd3 : blank_run_q + 2'd1;
      end else begin
        blank_run_d = 2'd0;
      end
    end
    squeezed = line_start_q && cfg_i.squeeze_blank && (blank_run_d > 2'd1);
    want_num = line_start_q && !squeezed &&
               (cfg_i.number_nonblank ? !is_nl : cfg_i.number_all);
  end

  always_comb begin
    dig   = 4'd0;
    carry = 1'b1;
    for (int i = 0; i < LINE_DIGITS; i++) begin
      carry = carry && (bcd_q[4*i +: 4] == 4'd9);
    end
    bcd_d = bcd_q;
    if (!carry) begin
      carry = 1'b1;
      for (int i = 0; i < LINE_DIGITS; i++) begin
        dig = bcd_q[4*i +: 4];
        if (carry) begin
          bcd_d[4*i +: 4] = (dig == 4'd9) ? 4'd0 : dig + 4'd1;
        end
        carry = carry && (dig == 4'd9);
      end
    end
  end

  always_comb begin
    c           = in_byte_i;
    n           = 3'd0;
    job_o.chars = '0;
    if (cfg_i.show_tabs && (in_byte_i == ChTab)) begin
      job_o.chars[0] = ChCaret;
      job_o.chars[1] = ChUpperI;
      n = 3'd2;
    end else begin
      if (cfg_i.show_ends && is_nl) begin
        job_o.chars[n[1:0]] = ChDollar;
        n = n + 3'd1;
      end
      if (cfg_i.show_nonprinting && !is_nl && (in_byte_i != ChTab)) begin
        if (c[7]) begin
          job_o.chars[n[1:0]] = ChUpperM;
          n = n + 3'd1;
          job_o.chars[n[1:0]] = ChDash;
          n = n + 3'd1;
          c = {1'b0, c[6:0]};
        end
        if (c <= CtrlLast) begin
          job_o.chars[n[1:0]] = ChCaret;
          n = n + 3'd1;
          c = c + CaretOfs;
        end else if (c == ChDel) begin
          job_o.chars[n[1:0]] = ChCaret;
          n = n + 3'd1;
          c = ChQuestion;
        end
      end
      job_o.chars[n[1:0]] = c;
      n = n + 3'd1;
    end
    job_o.char_cnt = n;
    job_o.has_num  = want_num;
  end

  assign push_o = accept && !squeezed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_start_q <= 1'b1;
      blank_run_q  <= 2'd0;
      bcd_q        <= NW'(1);
    end else if (accept) begin
      line_start_q <= is_nl;
      blank_run_q  <= blank_run_d;
      if (want_num) begin
        bcd_q <= bcd_d;
      end
    end
  end

endmodule

// File: sv/tscf_queue.sv
// Short first-in first-out queue between the front and back ends.
// Registered storage with a combinational head output.
// Depends on nothing; it is generic in width and depth.
module tscf_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  input  logic         pop_i,
  output logic [W-1:0] head_o,
  output logic         full_o,
  output logic         empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign head_o  = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/tscf_back.sv
// Back end of the text stream filter: expands one job into output beats.
// Walks the line number digits, the tab and the character bytes into an output register.
// Depends on tscf_pkg.
module tscf_back import tscf_pkg::*; #(
  parameter int LINE_DIGITS = LineDigitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  job_t                     job_i,
  input  logic [4*LINE_DIGITS-1:0] num_i,
  input  logic                     empty_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [7:0]               out_byte_o,
  output logic                     out_last_of_run_o
);

  localparam int IW = $clog2(LINE_DIGITS + ExpMax + 2);
  localparam int DW = (LINE_DIGITS > 1) ? $clog2(LINE_DIGITS) : 1;

  logic [3:0]    dig [LINE_DIGITS];
  logic [IW-1:0] idx_q, num_len, total, cofs;
  logic [DW-1:0] pos;
  logic          seen_q, out_valid_q, out_last_q;
  logic [7:0]    out_byte_q, byte_d;
  logic          in_num, at_tab, lead, last, adv;

  for (genvar g = 0; g < LINE_DIGITS; g++) begin : g_dig
    assign dig[g] = num_i[4*g +: 4];
  end

  always_comb begin
    num_len = job_i.has_num ? IW'(LINE_DIGITS + 1) : '0;
    total   = num_len + IW'(job_i.char_cnt);
    in_num  = job_i.has_num && (idx_q < IW'(LINE_DIGITS));
    at_tab  = job_i.has_num && (idx_q == IW'(LINE_DIGITS));
    pos     = DW'(LINE_DIGITS - 1) - idx_q[DW-1:0];
    lead    = !seen_q && (dig[pos] == 4'd0) && (pos != '0);
    cofs    = idx_q - num_len;
    if (in_num) begin
      byte_d = lead ? ChSpace : ChZero + {4'd0, dig[pos]};
    end else if (at_tab) begin
      byte_d = ChTab;
    end else begin
      byte_d = job_i.chars[cofs[1:0]];
    end
    last  = (idx_q == total - IW'(1));
    adv   = !empty_i && (!out_valid_q || out_ready_i);
    pop_o = adv && last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      seen_q      <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (adv) begin
        if (last) begin
          idx_q  <= '0;
          seen_q <= 1'b0;
        end else begin
          idx_q  <= idx_q + IW'(1);
          seen_q <= seen_q || (in_num && !lead);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= byte_d;
      out_last_q <= last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = out_byte_q;
  assign out_last_of_run_o = out_last_q;

endmodule

// File: sv/text_stream_cat_filter_core.sv
// Top level of the text stream filter: configuration registers, front, queue, back.
// Depends on tscf_pkg, tscf_front, tscf_queue and tscf_back.
//
// Input bytes arrive on a valid/ready channel, one beat per byte. Each byte
// turns into zero to eleven output beats on a valid/ready channel: an optional
// six-column line number and a tab at the start of a line, then the byte or
// its visible notation. The last output beat of a byte carries last_of_run.
// A squeezed blank line produces no output beat at all.
// The first output beat of a byte passes through the queue and the output
// register. The output side sends one beat per cycle while the receiver is
// ready, and the front keeps accepting bytes into a four-entry queue while
// the back expands.
// When the receiver stalls, the output register holds its beat, the queue
// fills and then the input ready drops. Configuration is written through a
// plain write port; the user must write it only while the block is idle, as
// the block does not enforce this. Reset clears the configuration, starts at
// the beginning of a line with line number one and empties the queue.
module text_stream_cat_filter_core import tscf_pkg::*; #(
  parameter int LINE_DIGITS = LineDigitsDef,
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               out_last_of_run_o
);

  localparam int NW = 4 * LINE_DIGITS;
  localparam int QW = $bits(job_t) + NW;

  cfg_t          cfg_q;
  job_t          push_job, head_job;
  logic [NW-1:0] push_num, head_num;
  logic          q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NUMBER_ALL:       cfg_q.number_all       <= cfg_data_i;
        CFG_NUMBER_NONBLANK:  cfg_q.number_nonblank  <= cfg_data_i;
        CFG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_data_i;
        CFG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_data_i;
        CFG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_data_i;
        CFG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tscf_front #(
    .LINE_DIGITS(LINE_DIGITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .job_o      (push_job),
    .num_o      (push_num)
  );

  tscf_queue #(
    .W    (QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i({push_job, push_num}),
    .pop_i      (q_pop),
    .head_o     ({head_job, head_num}),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  tscf_back #(
    .LINE_DIGITS(LINE_DIGITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_i            (head_job),
    .num_i            (head_num),
    .empty_i          (q_empty),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .out_last_of_run_o(out_last_of_run_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("Queue pushed while full.");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("Queue popped while empty.");

  a_back_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_empty && (!out_valid_o || out_ready_i)) |=> out_valid_o)
    else $error("Pending job did not reach the output register.");

  a_push_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (push_job.char_cnt != 3'd0))
    else $error("Job pushed without character bytes.");

endmodule

// File: verif/text_stream_cat_filter_checker.sv
`timescale 1ns / 1ps
// Checker for the text stream filter: watches the configuration port and both beat channels.
// Predicts the output beats of every accepted byte and compares them in order.
// Depends on tscf_pkg.
module text_stream_cat_filter_checker import tscf_pkg::*; #(
  parameter int LINE_DIGITS = LineDigitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         in_byte_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [7:0]         out_byte_i,
  input  logic               out_last_of_run_i,
  input  logic               end_of_run_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 byte_count_o,
  output int                 beat_count_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cat_beat_t;

  cfg_t                       opts;
  logic                       at_line_start;
  logic [1:0]                 blank_run;
  logic [4*LINE_DIGITS-1:0]   line_bcd;
  cat_beat_t                  cat_beats_q[$];
  int                         fails;
  int                         n_bytes;
  int                         n_beats;
  logic                       end_seen;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fails++;
  endtask

  task automatic push_beat(input logic [7:0] data);
    cat_beats_q.push_back('{data: data, last: 1'b0});
  endtask

  task automatic put_line_number();
    logic       leading;
    logic       all_nines;
    logic [3:0] digit;
    leading = 1'b1;
    for (int pos = LINE_DIGITS - 1; pos >= 0; pos--) begin
      digit = line_bcd[4*pos +: 4];
      if (digit != 4'd0 || pos == 0) leading = 1'b0;
      push_beat(leading ? ChSpace : ChZero + 8'(digit));
    end
    push_beat(ChTab);
    all_nines = 1'b1;
    for (int pos = 0; pos < LINE_DIGITS; pos++) begin
      if (line_bcd[4*pos +: 4] != 4'd9) all_nines = 1'b0;
    end
    if (!all_nines) begin
      for (int pos = 0; pos < LINE_DIGITS; pos++) begin
        if (line_bcd[4*pos +: 4] < 4'd9) begin
          line_bcd[4*pos +: 4] = line_bcd[4*pos +: 4] + 4'd1;
          break;
        end
        line_bcd[4*pos +: 4] = 4'd0;
      end
    end
  endtask

  task automatic put_visible(input logic [7:0] raw);
    logic [7:0] c;
    c = raw;
    if (opts.show_tabs && c == ChTab) begin
      push_beat(ChCaret);
      push_beat(ChUpperI);
      return;
    end
    if (opts.show_ends && c == ChNewline) push_beat(ChDollar);
    if (opts.show_nonprinting && c != ChNewline && c != ChTab) begin
      if (c[7]) begin
        push_beat(ChUpperM);
        push_beat(ChDash);
        c[7] = 1'b0;
      end
      if (c <= CtrlLast) begin
        push_beat(ChCaret);
        c = c + CaretOfs;
      end else if (c == ChDel) begin
        push_beat(ChCaret);
        c = ChQuestion;
      end
    end
    push_beat(c);
  endtask

  task automatic predict_cat_beats(input logic [7:0] raw);
    logic      blank;
    cat_beat_t tail;
    if (at_line_start) begin
      blank = (raw == ChNewline);
      if (blank) begin
        if (blank_run != 2'd3) blank_run = blank_run + 2'd1;
      end else begin
        blank_run = 2'd0;
      end
      if (opts.squeeze_blank && blank_run > 2'd1) return;
      if (opts.number_nonblank) begin
        if (!blank) put_line_number();
      end else if (opts.number_all) begin
        put_line_number();
      end
    end
    put_visible(raw);
    at_line_start = (raw == ChNewline);
    tail = cat_beats_q.pop_back();
    tail.last = 1'b1;
    cat_beats_q.push_back(tail);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cat_beat_t want;
    if (!rst_ni) begin
      opts = '0;
      at_line_start = 1'b1;
      blank_run = 2'd0;
      line_bcd = (4*LINE_DIGITS)'(1);
      cat_beats_q.delete();
      fails = 0;
      n_bytes = 0;
      n_beats = 0;
      end_seen = 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUMBER_ALL:       opts.number_all = cfg_data_i;
          CFG_NUMBER_NONBLANK:  opts.number_nonblank = cfg_data_i;
          CFG_SQUEEZE_BLANK:    opts.squeeze_blank = cfg_data_i;
          CFG_SHOW_ENDS:        opts.show_ends = cfg_data_i;
          CFG_SHOW_TABS:        opts.show_tabs = cfg_data_i;
          CFG_SHOW_NONPRINTING: opts.show_nonprinting = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        n_beats++;
        if (cat_beats_q.size() == 0) begin
          report_mismatch($sformatf("output beat %h with nothing expected", out_byte_i));
        end else begin
          want = cat_beats_q.pop_front();
          if (out_byte_i !== want.data)
            report_mismatch($sformatf("out_byte %h, expected %h", out_byte_i, want.data));
          if (out_last_of_run_i !== want.last)
            report_mismatch($sformatf("last_of_run %b, expected %b on byte %h",
                                      out_last_of_run_i, want.last, want.data));
        end
      end
      if (in_valid_i && in_ready_i) begin
        n_bytes++;
        predict_cat_beats(in_byte_i);
      end
      if (end_of_run_i && !end_seen) begin
        end_seen = 1'b1;
        if (cat_beats_q.size() != 0)
          report_mismatch($sformatf("%0d output beats never arrived", cat_beats_q.size()));
      end
    end
    fail_count_o <= fails;
    pending_o    <= cat_beats_q.size();
    byte_count_o <= n_bytes;
    beat_count_o <= n_beats;
  end

endmodule

// File: verif/text_stream_cat_filter_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the text stream filter: clock, reset, configuration phases and byte stimulus.
// Depends on tscf_pkg, text_stream_cat_filter_core and text_stream_cat_filter_checker.
module text_stream_cat_filter_core_tb;
  import tscf_pkg::*;

  localparam int SettleCycles = 200;
  localparam int RandPhases = 8;
  localparam int BytesPerPhase = 62;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic               cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         in_byte_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b1;
  logic [7:0]         out_byte_o;
  logic               out_last_of_run_o;
  logic               end_of_run;

  int   fail_count;
  int   pending;
  int   byte_count;
  int   beat_count;
  int   bytes_sent = 0;
  int   phase_cnt = 0;
  int   stall_hold = 0;
  logic idle_on;
  logic stall_on;

  always #1 clk_i = ~clk_i;

  text_stream_cat_filter_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_byte_i        (in_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .out_last_of_run_o(out_last_of_run_o)
  );

  text_stream_cat_filter_checker #(
    .LINE_DIGITS(LineDigitsDef)
  ) i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_byte_i        (in_byte_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_i       (out_byte_o),
    .out_last_of_run_i(out_last_of_run_o),
    .end_of_run_i     (end_of_run),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .byte_count_o     (byte_count),
    .beat_count_o     (beat_count)
  );

  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
      if (stall_hold == 1) out_ready_i <= 1'b1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_hold <= $urandom_range(1, 5);
    end
  end

  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(0, 255));
      1:       return ChTab;
      2:       return 8'($urandom_range(0, 31));
      3:       return ChDel;
      4:       return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_line();
    repeat ($urandom_range(0, 12)) send_byte(pick_text_byte());
    send_byte(ChNewline);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) send_byte(ChNewline);
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Indexes past the last register are written too; they must leave the block unchanged.
  task automatic load_config(input cfg_t c);
    localparam int LastIdx = int'(CFG_SHOW_NONPRINTING);
    cfg_we_i <= 1'b1;
    for (int i = 0; i < 2**CfgIdxW; i++) begin
      cfg_idx_i <= CfgIdxW'(i);
      if (i <= LastIdx) cfg_data_i <= c[LastIdx - i];
      else cfg_data_i <= 1'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    phase_cnt++;
  endtask

  initial begin
    cfg_t       c;
    int         phase_base;
    logic [7:0] plain_seq[3]  = '{8'h00, 8'hFF, 8'h0A};
    logic [7:0] show_seq[12]  = '{8'h09, 8'h89, 8'h80, 8'hFF, 8'h7F, 8'h1F,
                                  8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h41, 8'h0A};
    logic [7:0] blank_seq[6]  = '{8'h0A, 8'h0A, 8'h20, 8'h09, 8'h7E, 8'h0A};
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = 1'b0;
    in_valid_i  = 1'b0;
    in_byte_i   = 8'h00;
    end_of_run  = 1'b0;
    idle_on     = 1'b1;
    stall_on    = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plain_seq[i]) send_byte(plain_seq[i]);
    wait_quiet();

    c = '1;
    c.number_nonblank = 1'b0;
    load_config(c);
    foreach (show_seq[i]) send_byte(show_seq[i]);
    wait_quiet();

    c = '0;
    c.number_all = 1'b1;
    c.number_nonblank = 1'b1;
    c.squeeze_blank = 1'b1;
    c.show_nonprinting = 1'b1;
    load_config(c);
    foreach (blank_seq[i]) send_byte(blank_seq[i]);
    wait_quiet();

    for (int p = 0; p < RandPhases; p++) begin
      if (p == 0) c = '1;
      else if (p == 1) c = '0;
      else c = 6'($urandom);
      if (p == RandPhases - 1) begin
        idle_on  <= 1'b0;
        stall_on <= 1'b0;
      end
      load_config(c);
      phase_base = bytes_sent;
      while (bytes_sent < phase_base + BytesPerPhase) send_line();
      wait_quiet();
    end

    end_of_run <= 1'b1;
    repeat (2) @(posedge clk_i);
    $display("Sent %0d text bytes in %0d configuration phases, including unused register writes,",
             byte_count, phase_cnt + 1);
    $display("and checked %0d output beats with random gaps and stalls on both channels.",
             beat_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
sv/tscf_pkg.sv
sv/tscf_front.sv
sv/tscf_queue.sv
sv/tscf_back.sv
sv/text_stream_cat_filter_core.sv
verif/text_stream_cat_filter_checker.sv
verif/text_stream_cat_filter_core_tb.sv
